[sv/obfv_pkg.sv]
// ----------------------------------------------------------------------------
// obfv_pkg: shared types and constants
// Types and fixed widths used by the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package obfv_pkg;

	// Width of one vector component and of a sum of two squares.
	localparam int DW = 16;
	localparam int SW = 32;

	// Largest magnitude kept before the sign is applied.
	localparam logic [16:0] MAG_LIMIT = 17'd32768;
	localparam logic [16:0] POS_LIMIT = 17'd32767;

	// Per-item side information that travels beside the arithmetic.
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 sel_x;
		logic                 neg_z;
		logic                 neg_v;
		logic                 degen;
	} sb_t;

	// One result transaction.
	typedef struct packed {
		logic signed [DW-1:0] tan_x;
		logic signed [DW-1:0] tan_y;
		logic signed [DW-1:0] tan_z;
		logic signed [DW-1:0] bitan_x;
		logic signed [DW-1:0] bitan_y;
		logic signed [DW-1:0] bitan_z;
		logic                 degenerate;
	} frame_t;

endpackage

[sv/obfv_vec_if.sv]
// ----------------------------------------------------------------------------
// obfv_vec_if: input vector channel
// Valid/ready channel carrying one signed fixed-point 3D vector.
// ----------------------------------------------------------------------------
interface obfv_vec_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] in_x;
	logic signed [15:0] in_y;
	logic signed [15:0] in_z;

	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
	modport mon    (input valid, ready, in_x, in_y, in_z);
endinterface

[sv/obfv_frame_if.sv]
// ----------------------------------------------------------------------------
// obfv_frame_if: result frame channel
// Valid/ready channel carrying the tangent, bitangent and degenerate flag.
// ----------------------------------------------------------------------------
interface obfv_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tan_x;
	logic signed [15:0] tan_y;
	logic signed [15:0] tan_z;
	logic signed [15:0] bitan_x;
	logic signed [15:0] bitan_y;
	logic signed [15:0] bitan_z;
	logic               degenerate;

	modport source (output valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
		degenerate, input ready);
	modport sink   (input valid, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
		degenerate, output ready);
	modport mon    (input valid, ready, tan_x, tan_y, tan_z, bitan_x, bitan_y,
		bitan_z, degenerate);
endinterface

[sv/obfv_front.sv]
// ----------------------------------------------------------------------------
// obfv_front: magnitude, branch select and sum of squares
// Three stages: magnitudes and branch, squares, sum of squares.
// ----------------------------------------------------------------------------
module obfv_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  logic signed [15:0]         x,
	input  logic signed [15:0]         y,
	input  logic signed [15:0]         z,
	output logic                       v_out,
	output obfv_pkg::sb_t              sb_out,
	output logic [obfv_pkg::SW-1:0]    s_out,
	output logic [obfv_pkg::SW-1:0]    na_out,
	output logic [obfv_pkg::SW-1:0]    nz_out
);
	import obfv_pkg::*;

	logic [DW-1:0] ax, ay, az;
	logic [DW-1:0] va_s1, az_s1;
	sb_t           sb_s1, sb_s2, sb_s3, sb_c;
	logic          v_s1, v_s2, v_s3;
	logic [SW-1:0] na_s2, nz_s2, na_s3, nz_s3, s_s3;

	// Magnitudes; the negation of the most negative value gives 32768.
	assign ax = x[DW-1] ? DW'(-x) : DW'(x);
	assign ay = y[DW-1] ? DW'(-y) : DW'(y);
	assign az = z[DW-1] ? DW'(-z) : DW'(z);

	always_comb begin
		sb_c.x     = x;
		sb_c.y     = y;
		sb_c.z     = z;
		sb_c.sel_x = ax > ay;
		sb_c.neg_z = z[DW-1];
		sb_c.neg_v = (ax > ay) ? (x > 0) : (y > 0);
		sb_c.degen = (x == 0) && (y == 0) && (z == 0);
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage data: select, square, then sum.
	always_ff @(posedge clk) begin
		if (en) begin
			va_s1 <= (ax > ay) ? ax : ay;
			az_s1 <= az;
			sb_s1 <= sb_c;
			na_s2 <= SW'(va_s1) * SW'(va_s1);
			nz_s2 <= SW'(az_s1) * SW'(az_s1);
			sb_s2 <= sb_s1;
			s_s3  <= na_s2 + nz_s2;
			na_s3 <= na_s2;
			nz_s3 <= nz_s2;
			sb_s3 <= sb_s2;
		end
	end

	assign v_out  = v_s3;
	assign sb_out = sb_s3;
	assign s_out  = s_s3;
	assign na_out = na_s3;
	assign nz_out = nz_s3;
endmodule

[sv/obfv_div.sv]
// ----------------------------------------------------------------------------
// obfv_div: pipelined restoring divider
// Computes floor(num * 4^(FRAC_BITS+1) / den) for num <= den, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module obfv_div #(
	parameter int FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [obfv_pkg::SW-1:0]       num,
	input  logic [obfv_pkg::SW-1:0]       den,
	output logic [2*FRAC_BITS+2:0]        quo
);
	import obfv_pkg::*;

	localparam int QW = 2 * FRAC_BITS + 3;
	localparam int ND = QW;

	logic [SW-1:0] rem_s [0:ND-1];
	logic [SW-1:0] den_s [0:ND-1];
	logic [QW-1:0] quo_s [0:ND-1];
	logic          ge0;

	// First stage: integer part of num / den, which is 0 or 1.
	assign ge0 = num >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ge0 ? (num - den) : num;
			den_s[0] <= den;
			quo_s[0] <= QW'(ge0);
		end
	end

	// Fraction stages: shift in a zero bit, subtract when it fits.
	for (genvar k = 1; k < ND; k++) begin : g_step
		logic [SW:0] t;
		logic [SW:0] d;
		logic        ge;

		assign t  = {rem_s[k-1], 1'b0};
		assign d  = {1'b0, den_s[k-1]};
		assign ge = t >= d;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? SW'(t - d) : t[SW-1:0];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[ND-1];
endmodule

[sv/obfv_sqrt.sv]
// ----------------------------------------------------------------------------
// obfv_sqrt: pipelined integer square root
// Digit-by-digit restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module obfv_sqrt #(
	parameter int FRAC_BITS = 14
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [2*FRAC_BITS+2:0]    rad,
	output logic [FRAC_BITS+1:0]      root
);
	localparam int RW = FRAC_BITS + 2;
	localparam int QW = 2 * FRAC_BITS + 3;

	logic [2*RW-1:0] rad_s  [0:RW];
	logic [RW+1:0]   rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];

	// Entry point of the chain.
	assign rad_s[0]  = {{(2*RW-QW){1'b0}}, rad};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	// Each stage brings down two radicand bits and tries root*4+1.
	for (genvar i = 1; i <= RW; i++) begin : g_step
		logic [RW+3:0] t;
		logic [RW+3:0] trial;
		logic          ge;

		assign t     = {rem_s[i-1], rad_s[i-1][2*RW-1 -: 2]};
		assign trial = {2'b00, root_s[i-1], 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
				root_s[i] <= {root_s[i-1][RW-2:0], ge};
				rad_s[i]  <= {rad_s[i-1][2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW];
endmodule

[sv/obfv_back.sv]
// ----------------------------------------------------------------------------
// obfv_back: tangent rounding and cross product
// Three stages: tangent from roots, partial products, difference with
// rounding and saturation.
// ----------------------------------------------------------------------------
module obfv_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  obfv_pkg::sb_t         sb_in,
	input  logic [FRAC_BITS+1:0]  ra,
	input  logic [FRAC_BITS+1:0]  rz,
	output logic                  v_out,
	output obfv_pkg::frame_t      frame_out
);
	import obfv_pkg::*;

	localparam int RW = FRAC_BITS + 2;
	localparam int MW = (RW + 1 > 17) ? RW + 1 : 17;
	localparam int PW = 2 * DW;

	// Rounded magnitude is (root + 1) / 2, clamped and then signed.
	function automatic logic signed [DW-1:0] to_tan(input logic [RW-1:0] r,
		input logic neg);
		logic [MW-1:0] n;
		logic [16:0]   m;
		n = MW'((MW'(r) + MW'(1)) >> 1);
		m = (n > MW'(MAG_LIMIT)) ? MAG_LIMIT : n[16:0];
		if (neg)
			to_tan = DW'(-m);
		else
			to_tan = (m > POS_LIMIT) ? DW'(POS_LIMIT) : DW'(m);
	endfunction

	// Rounds a product difference to nearest, ties away, and saturates.
	function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PW:0] d);
		logic [PW:0]   mag;
		logic [PW+1:0] m;
		mag = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
		m   = ((PW+2)'(mag) + ((PW+2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (d[PW])
			rnd_sat = (m > (PW+2)'(MAG_LIMIT)) ? DW'(MAG_LIMIT) : DW'(-m);
		else
			rnd_sat = (m > (PW+2)'(POS_LIMIT)) ? DW'(POS_LIMIT) : DW'(m);
	endfunction

	logic                  v_s1, v_s2, v_s3;
	logic signed [DW-1:0]  t_s1 [0:2];
	logic signed [DW-1:0]  t_s2 [0:2];
	sb_t                   sb_s1, sb_s2;
	logic signed [PW-1:0]  p_s2 [0:5];
	frame_t                f_s3;
	logic signed [DW-1:0]  tz_c, tv_c;

	assign tz_c = to_tan(rz, sb_in.neg_z);
	assign tv_c = to_tan(ra, sb_in.neg_v);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: place the tangent components by branch; zero input forces zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1   <= sb_in;
			t_s1[0] <= (sb_in.degen || !sb_in.sel_x) ? '0 : tz_c;
			t_s1[1] <= (sb_in.degen ||  sb_in.sel_x) ? '0 : tz_c;
			t_s1[2] <= sb_in.degen ? '0 : tv_c;
		end
	end

	// Stage 2: the six products of the cross product.
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2   <= sb_s1;
			t_s2    <= t_s1;
			p_s2[0] <= t_s1[1] * sb_s1.z;
			p_s2[1] <= t_s1[2] * sb_s1.y;
			p_s2[2] <= t_s1[2] * sb_s1.x;
			p_s2[3] <= t_s1[0] * sb_s1.z;
			p_s2[4] <= t_s1[0] * sb_s1.y;
			p_s2[5] <= t_s1[1] * sb_s1.x;
		end
	end

	// Stage 3: differences, rounding and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s3.tan_x      <= t_s2[0];
			f_s3.tan_y      <= t_s2[1];
			f_s3.tan_z      <= t_s2[2];
			f_s3.bitan_x    <= rnd_sat((PW+1)'(p_s2[0]) - (PW+1)'(p_s2[1]));
			f_s3.bitan_y    <= rnd_sat((PW+1)'(p_s2[2]) - (PW+1)'(p_s2[3]));
			f_s3.bitan_z    <= rnd_sat((PW+1)'(p_s2[4]) - (PW+1)'(p_s2[5]));
			f_s3.degenerate <= sb_s2.degen;
		end
	end

	assign v_out     = v_s3;
	assign frame_out = f_s3;
endmodule

[sv/orthonormal_basis_from_vector.sv]
// ----------------------------------------------------------------------------
// orthonormal_basis_from_vector: tangent frame from a fixed-point vector
// Pipelined computation of a tangent and a bitangent for a 3D vector.
// ----------------------------------------------------------------------------
// The block takes one vector per cycle, except while the pipeline holds, and
// returns its tangent and bitangent in input order. The dividers produce one
// quotient bit per stage (2*FRAC_BITS+3 stages) and the square roots produce
// one root bit per stage (FRAC_BITS+2 stages); three stages in front, three
// behind and the output register complete the path. A one-entry skid
// register behind the pipeline lets a new vector in while a result waits;
// the pipeline holds only when both the output and the skid entry are full.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_vector #(
	parameter int FRAC_BITS = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	obfv_vec_if.sink      vec,
	obfv_frame_if.source  frame
);
	import obfv_pkg::*;

	localparam int RW = FRAC_BITS + 2;
	localparam int QW = 2 * FRAC_BITS + 3;
	localparam int D  = QW + RW;

	logic          en;
	logic          fv;
	sb_t           fsb;
	logic [SW-1:0] s, na, nz;
	logic [QW-1:0] qa, qz;
	logic [RW-1:0] ra, rz;
	sb_t           sb_dly_s [0:D];
	logic          v_dly_s  [0:D];
	logic          bv;
	frame_t        bf;
	frame_t        out_q, skid_q;
	logic          out_valid_q, skid_full_q;

	assign en        = !skid_full_q;
	assign vec.ready = en;

	obfv_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(vec.valid),
		.x(vec.in_x), .y(vec.in_y), .z(vec.in_z),
		.v_out(fv), .sb_out(fsb), .s_out(s), .na_out(na), .nz_out(nz)
	);

	obfv_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
		.clk(clk), .en(en), .num(na), .den(s), .quo(qa)
	);
	obfv_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk(clk), .en(en), .num(nz), .den(s), .quo(qz)
	);

	obfv_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_a (
		.clk(clk), .en(en), .rad(qa), .root(ra)
	);
	obfv_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_z (
		.clk(clk), .en(en), .rad(qz), .root(rz)
	);

	// Side information and valid bits follow the divider and root stages.
	assign sb_dly_s[0] = fsb;
	assign v_dly_s[0]  = fv;

	for (genvar i = 1; i <= D; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_dly_s[i] <= 1'b0;
			else if (en)
				v_dly_s[i] <= v_dly_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en)
				sb_dly_s[i] <= sb_dly_s[i-1];
		end
	end

	obfv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_dly_s[D]),
		.sb_in(sb_dly_s[D]), .ra(ra), .rz(rz), .v_out(bv), .frame_out(bf)
	);

	// Output register and skid entry: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (frame.ready)
				skid_full_q <= 1'b0;
		end else if (bv) begin
			if (out_valid_q && !frame.ready)
				skid_full_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register and skid entry: data.
	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (frame.ready)
				out_q <= skid_q;
		end else if (bv) begin
			if (out_valid_q && !frame.ready)
				skid_q <= bf;
			else
				out_q <= bf;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.tan_x      = out_q.tan_x;
	assign frame.tan_y      = out_q.tan_y;
	assign frame.tan_z      = out_q.tan_z;
	assign frame.bitan_x    = out_q.bitan_x;
	assign frame.bitan_y    = out_q.bitan_y;
	assign frame.bitan_z    = out_q.bitan_z;
	assign frame.degenerate = out_q.degenerate;
endmodule

[sv/obfv_checker.sv]
// ----------------------------------------------------------------------------
// obfv_checker: port-level checks for the basis block
// Concurrent assertions on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
module obfv_checker (
	input logic           clk,
	input logic           arst_n,
	obfv_vec_if.sink      vec,
	obfv_frame_if.source  frame
);
	// A zero input gives an all-zero frame.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.degenerate |-> frame.tan_x == 0 && frame.tan_y == 0 &&
		frame.tan_z == 0 && frame.bitan_x == 0 && frame.bitan_y == 0 &&
		frame.bitan_z == 0)
		else $error("degenerate frame with nonzero components");

	// The tangent always lies in the xz or the yz plane.
	a_tan_plane: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> frame.tan_x == 0 || frame.tan_y == 0)
		else $error("tangent has both x and y components");

	// Input backpressure only happens behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> frame.valid)
		else $error("input stalled with no result waiting");

	// A taken result frees the input side in the next cycle.
	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready && frame.ready |=> vec.ready)
		else $error("input still stalled after result transaction");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && !frame.ready |=> frame.valid)
		else $error("result withdrawn while stalled");
endmodule

bind orthonormal_basis_from_vector obfv_checker u_obfv_checker (
	.clk(clk), .arst_n(arst_n), .vec(vec), .frame(frame)
);

[bench/orthonormal_basis_from_vector_tb.sv]
// ----------------------------------------------------------------------------
// orthonormal_basis_from_vector_tb: self-checking bench for the frame pipeline
// Sends directed and random vectors through the block and compares each
// returned tangent, bitangent and degenerate flag with a predicted frame.
// The bench runs under several idle and stall mixes and includes one long
// output stall.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_vector_tb;
	import obfv_pkg::*;

	localparam int FRAC_BITS = 14;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 340;
	localparam int N_DIRECTED = 16;

	// Directed rows: x, y, z, typed flag, then tan x/y/z, bitan x/y/z, degenerate.
	localparam int DIRECTED [N_DIRECTED][11] = '{
		'{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1},
		'{16384, 0, 0, 1, 0, 0, -16384, 0, -16384, 0, 0},
		'{0, 16384, 0, 1, 0, 0, -16384, 16384, 0, 0, 0},
		'{0, 0, 1, 1, 0, 16384, 0, 1, 0, 0, 0},
		'{32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
		'{100, -100, 5, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-32768, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{32767, -32768, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-1, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
		'{-21845, 10922, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 32767, 0, 0, 0, 0, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	obfv_vec_if   vec();
	obfv_frame_if frame();

	orthonormal_basis_from_vector #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.vec   (vec),
		.frame (frame)
	);

	frame_t pending_frames[$];
	int     mismatches = 0;
	int     vectors_sent = 0;
	int     frames_seen = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     quiet_cycles = 0;
	bit     hold_go = 0;
	int     hold_left = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Rounded magnitude of vm * 2^F / sqrt(s), searched over 0..32768.
	function automatic longint unsigned scaled_mag(longint unsigned vm, longint unsigned s);
		longint unsigned lo, hi, mid, d;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			d = 2 * mid - 1;
			if (vm != 0 && d * d * s <= ((vm * vm) << (2 * FRAC_BITS + 2)))
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint clamp16(bit neg, longint unsigned mag);
		if (neg)
			return (mag > 32768) ? -32768 : -longint'(mag);
		return (mag > 32767) ? 32767 : longint'(mag);
	endfunction

	function automatic longint shift_round(longint p);
		longint unsigned m;
		m = (p < 0) ? longint'(-p) : p;
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return clamp16(p < 0, m);
	endfunction

	// Expected frame for one input vector.
	function automatic frame_t predict_frame(logic signed [15:0] vx, logic signed [15:0] vy,
		logic signed [15:0] vz);
		frame_t f;
		longint x, y, z, t0, t1, t2;
		longint unsigned ax, ay, az, s;
		x = longint'(vx);
		y = longint'(vy);
		z = longint'(vz);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		t0 = 0;
		t1 = 0;
		t2 = 0;
		f = '0;
		if (x == 0 && y == 0 && z == 0) begin
			f.degenerate = 1'b1;
			return f;
		end
		if (ax > ay) begin
			s = ax * ax + az * az;
			t0 = clamp16(z < 0, scaled_mag(az, s));
			t2 = clamp16(x > 0, scaled_mag(ax, s));
		end else begin
			s = ay * ay + az * az;
			t1 = clamp16(z < 0, scaled_mag(az, s));
			t2 = clamp16(y > 0, scaled_mag(ay, s));
		end
		f.tan_x = 16'(t0);
		f.tan_y = 16'(t1);
		f.tan_z = 16'(t2);
		f.bitan_x = 16'(shift_round(t1 * z - t2 * y));
		f.bitan_y = 16'(shift_round(t2 * x - t0 * z));
		f.bitan_z = 16'(shift_round(t0 * y - t1 * x));
		return f;
	endfunction

	// Offer one vector and hold it until the block takes it.
	task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z, frame_t want);
		while ($urandom_range(99) < idle_pct) begin
			vec.valid <= 1'b0;
			@(posedge clk);
		end
		vec.valid <= 1'b1;
		vec.in_x <= x;
		vec.in_y <= y;
		vec.in_z <= z;
		@(negedge clk);
		while (!vec.ready)
			@(negedge clk);
		pending_frames.push_back(want);
		vectors_sent++;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(64)) - 32);
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			3: return '0;
			default: return 16'($signed($urandom_range(4096)) - 2048);
		endcase
	endfunction

	task automatic send_random;
		logic signed [15:0] x, y, z;
		x = rand_comp($urandom_range(9) < 5 ? 0 : $urandom_range(4));
		y = rand_comp($urandom_range(9) < 5 ? 0 : $urandom_range(4));
		z = rand_comp($urandom_range(9) < 5 ? 0 : $urandom_range(4));
		// Now and then force equal magnitudes of x and y.
		if ($urandom_range(15) == 0)
			y = $urandom_range(1) ? x : -x;
		send_vector(x, y, z, predict_frame(x, y, z));
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	// Receiver: random stalls, plus one long hold when requested.
	always @(posedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_go <= 1'b0;
			hold_left <= HOLD_CYCLES;
			frame.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			frame.ready <= (hold_left == 1);
		end else begin
			frame.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result check against the oldest expected frame.
	always @(negedge clk) begin
		frame_t want;
		if (arst_n && frame.valid && frame.ready) begin
			frames_seen++;
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tan %0d %0d %0d",
					$time, frame.tan_x, frame.tan_y, frame.tan_z);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				if (frame.tan_x !== want.tan_x) begin
					report("tan_x", want.tan_x, frame.tan_x); mismatches++; end
				if (frame.tan_y !== want.tan_y) begin
					report("tan_y", want.tan_y, frame.tan_y); mismatches++; end
				if (frame.tan_z !== want.tan_z) begin
					report("tan_z", want.tan_z, frame.tan_z); mismatches++; end
				if (frame.bitan_x !== want.bitan_x) begin
					report("bitan_x", want.bitan_x, frame.bitan_x); mismatches++; end
				if (frame.bitan_y !== want.bitan_y) begin
					report("bitan_y", want.bitan_y, frame.bitan_y); mismatches++; end
				if (frame.bitan_z !== want.bitan_z) begin
					report("bitan_z", want.bitan_z, frame.bitan_z); mismatches++; end
				if (frame.degenerate !== want.degenerate) begin
					report("degenerate", want.degenerate, frame.degenerate); mismatches++; end
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(negedge clk) begin
		if ((vec.valid && vec.ready) || (frame.valid && frame.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		frame_t want;
		arst_n = 1'b0;
		vec.valid = 1'b0;
		vec.in_x = '0;
		vec.in_y = '0;
		vec.in_z = '0;
		frame.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; typed rows carry their own expected frame.
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i][3] != 0) begin
				want.tan_x = 16'(DIRECTED[i][4]);
				want.tan_y = 16'(DIRECTED[i][5]);
				want.tan_z = 16'(DIRECTED[i][6]);
				want.bitan_x = 16'(DIRECTED[i][7]);
				want.bitan_y = 16'(DIRECTED[i][8]);
				want.bitan_z = 16'(DIRECTED[i][9]);
				want.degenerate = 1'(DIRECTED[i][10]);
			end else begin
				want = predict_frame(16'(DIRECTED[i][0]), 16'(DIRECTED[i][1]),
					16'(DIRECTED[i][2]));
			end
			send_vector(16'(DIRECTED[i][0]), 16'(DIRECTED[i][1]), 16'(DIRECTED[i][2]),
				want);
		end

		// Random phases with different idle and stall mixes.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Long output hold while inputs keep coming, to fill the pipeline.
				if (phase == 0 && n == 100)
					hold_go = 1'b1;
				send_random();
			end
		end
		vec.valid <= 1'b0;
		stall_pct = 0;

		wait (pending_frames.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d vectors (directed and random, four idle/stall mixes", vectors_sent);
		$display("and one long output hold); checked %0d result frames.", frames_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
